[rtl/btr_pkg.sv]
package btr_pkg;

  localparam int BIN_W     = 27;
  localparam int BCD_W     = 32;
  localparam int CMD_W     = 2;
  localparam int POS_W     = 3;
  localparam int DIG_W     = 4;
  localparam int CNT_W     = 5;
  localparam int CFG_IDX_W = 1;
  localparam int BCD_SLOTS = 8;

  localparam logic [BCD_W-1:0] RESET_BCD = 32'h1407_0000;
  localparam logic [BIN_W-1:0] MIN_RESET = 27'd500000;
  localparam logic [BIN_W-1:0] MAX_RESET = 27'd39999999;

  localparam logic [DIG_W-1:0] DIG_ZERO  = 4'd0;
  localparam logic [DIG_W-1:0] DIG_ONE   = 4'd1;
  localparam logic [DIG_W-1:0] DIG_THREE = 4'd3;
  localparam logic [DIG_W-1:0] DIG_FIVE  = 4'd5;
  localparam logic [DIG_W-1:0] DIG_NINE  = 4'd9;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX = 1'd1;

  typedef enum logic [CMD_W-1:0] {
    CMD_UP    = 2'd0,
    CMD_DOWN  = 2'd1,
    CMD_ENTER = 2'd2,
    CMD_LOAD  = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    CELL_HOLD,
    CELL_SAVE,
    CELL_RESTORE,
    CELL_ROTATE,
    CELL_CLEAR,
    CELL_DABBLE,
    CELL_STEP,
    CELL_CARRY,
    CELL_ENTER
  } cell_op_t;

  typedef struct packed {
    cell_op_t           op;
    logic               up;
    logic [POS_W-1:0]   pos;
    logic [DIG_W-1:0]   digit;
  } cell_ctrl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_CARRY,
    ST_SCAN,
    ST_JUDGE,
    ST_DABBLE,
    ST_MEASURE,
    ST_DONE
  } state_t;

  // 10^n - 1, capped at the largest binary value
  function automatic logic [BIN_W-1:0] top_cap(input int n);
    longint p;
    p = 1;
    for (int i = 0; i < n; i++) begin
      p = p * 10;
    end
    p = p - 1;
    if (p > longint'((1 << BIN_W) - 1)) begin
      return '1;
    end
    return BIN_W'(p);
  endfunction

  function automatic logic [DIG_W-1:0] reset_digit(input int n, input int i);
    if (n < BCD_SLOTS) begin
      return DIG_NINE;
    end
    if (i >= BCD_SLOTS) begin
      return DIG_ZERO;
    end
    return RESET_BCD[DIG_W*i +: DIG_W];
  endfunction

endpackage

[rtl/btr_if.sv]
interface btr_in_if;
  logic                         valid;
  logic                         ready;
  logic [btr_pkg::CMD_W-1:0]    cmd;
  logic [btr_pkg::POS_W-1:0]    position;
  logic [btr_pkg::DIG_W-1:0]    digit_in;
  logic [btr_pkg::BIN_W-1:0]    load_value;

  modport source (output valid, cmd, position, digit_in, load_value, input ready);
  modport sink   (input valid, cmd, position, digit_in, load_value, output ready);
endinterface

interface btr_out_if;
  logic                         valid;
  logic                         ready;
  logic [btr_pkg::BIN_W-1:0]    value_out;
  logic [btr_pkg::BCD_W-1:0]    bcd_out;
  logic                         changed;

  modport source (output valid, value_out, bcd_out, changed, input ready);
  modport sink   (input valid, value_out, bcd_out, changed, output ready);
endinterface

[rtl/btr_cell.sv]
module btr_cell #(
  parameter int                          IDX       = 0,
  parameter logic [btr_pkg::DIG_W-1:0]   RST_DIGIT = '0
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  btr_pkg::cell_ctrl_t           ctrl,
  input  logic [btr_pkg::DIG_W-1:0]     rot_in,
  input  logic                          carry_in,
  input  logic                          dab_in,
  output logic [btr_pkg::DIG_W-1:0]     digit,
  output logic                          carry_out,
  output logic                          dab_out,
  output logic                          diff
);
  import btr_pkg::*;

  logic [DIG_W-1:0] digit_r, digit_nxt, save_r;
  logic [DIG_W-1:0] adj, limit, wrap, stepped;
  logic             cy_r, cy_nxt;
  logic             sel, hit;

  assign sel = (IDX < (1 << POS_W)) && (ctrl.pos == POS_W'(IDX));

  always_comb begin
    adj     = (digit_r >= DIG_FIVE) ? digit_r + DIG_THREE : digit_r;
    limit   = ctrl.up ? DIG_NINE : DIG_ZERO;
    wrap    = ctrl.up ? DIG_ZERO : DIG_NINE;
    stepped = ctrl.up ? digit_r + DIG_ONE : digit_r - DIG_ONE;
    hit     = ((ctrl.op == CELL_STEP) && sel) || ((ctrl.op == CELL_CARRY) && carry_in);
    digit_nxt = digit_r;
    cy_nxt    = 1'b0;
    case (ctrl.op)
      CELL_RESTORE: digit_nxt = save_r;
      CELL_ROTATE:  digit_nxt = rot_in;
      CELL_CLEAR:   digit_nxt = DIG_ZERO;
      CELL_DABBLE:  digit_nxt = {adj[DIG_W-2:0], dab_in};
      CELL_ENTER: begin
        if (sel) begin
          digit_nxt = ctrl.digit;
        end
      end
      CELL_STEP, CELL_CARRY: begin
        if (hit) begin
          if (digit_r == limit) begin
            digit_nxt = wrap;
            cy_nxt    = 1'b1;
          end else begin
            digit_nxt = stepped;
          end
        end
      end
      default: digit_nxt = digit_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      digit_r <= RST_DIGIT;
      cy_r    <= 1'b0;
    end else begin
      digit_r <= digit_nxt;
      cy_r    <= cy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.op == CELL_SAVE) begin
      save_r <= digit_r;
    end
  end

  assign digit     = digit_r;
  assign carry_out = cy_r;
  assign dab_out   = adj[DIG_W-1];
  assign diff      = (digit_r != save_r);

endmodule

[rtl/btr_chain.sv]
module btr_chain #(
  parameter int NUM_DIGITS = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  btr_pkg::cell_ctrl_t           ctrl,
  input  logic                          dab_in,
  output logic [btr_pkg::DIG_W-1:0]     digits [NUM_DIGITS],
  output logic                          top_carry,
  output logic                          any_diff
);
  import btr_pkg::*;

  logic [NUM_DIGITS-1:0] carry_v, dab_v, diff_v;

  for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_cell
    logic cin, din;
    if (i == 0) begin : g_first
      assign cin = 1'b0;
      assign din = dab_in;
    end else begin : g_rest
      assign cin = carry_v[i-1];
      assign din = dab_v[i-1];
    end

    btr_cell #(
      .IDX       (i),
      .RST_DIGIT (reset_digit(NUM_DIGITS, i))
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .rot_in    (digits[(i + NUM_DIGITS - 1) % NUM_DIGITS]),
      .carry_in  (cin),
      .dab_in    (din),
      .digit     (digits[i]),
      .carry_out (carry_v[i]),
      .dab_out   (dab_v[i]),
      .diff      (diff_v[i])
    );
  end

  assign top_carry = carry_v[NUM_DIGITS-1];
  assign any_diff  = |diff_v;

endmodule

[rtl/bcd_tuning_register_top.sv]
// Channel   Dir  Payload                                Transfer
// in_ch     in   cmd, position, digit_in, load_value    valid && ready
// out_ch    out  value_out, bcd_out, changed            valid && ready
// cfg_*     in   cfg_index, cfg_data                    cfg_we
//
// Each item ends by measuring the digits. A step first carries, scans and
// judges, but is restored and measured at once when the carry runs off the
// top digit; enter digit scans, judges and dabbles; load dabbles; an ignored
// item only measures. Digits pass one cell per cycle around the cell ring for
// BCD to binary; binary to BCD shifts one bit per cycle into the cell row.
// One item in flight; the next item is taken while a result waits in out_ch.
// Synchronous active-low reset restores the range registers and the digits.
module bcd_tuning_register_top #(
  parameter int NUM_DIGITS = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [btr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [btr_pkg::BIN_W-1:0]         cfg_data,
  btr_in_if.sink                            in_ch,
  btr_out_if.source                         out_ch
);
  import btr_pkg::*;

  localparam logic [BIN_W-1:0] TOP_VAL = top_cap(NUM_DIGITS);
  localparam int               SHOWN   = (NUM_DIGITS < BCD_SLOTS) ? NUM_DIGITS : BCD_SLOTS;
  localparam logic [CNT_W-1:0] LAST_DIG = CNT_W'(NUM_DIGITS - 1);
  localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(BIN_W - 1);

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [BIN_W-1:0]   min_r, max_r, lo_r, hi_r;
  cmd_t               cmd_r;
  logic [POS_W-1:0]   pos_r;
  logic [DIG_W-1:0]   dig_r;
  logic [BIN_W-1:0]   load_r;
  logic               clamp_mode_r, clamp_mode_nxt;
  logic               ovf_r, ovf_nxt;
  logic [BIN_W-1:0]   acc_r, acc_nxt;
  logic               big_r, big_nxt;
  logic [BIN_W-1:0]   c_r, c_nxt;
  logic               out_valid_r;
  logic [BIN_W-1:0]   value_r;
  logic [BCD_W-1:0]   bcd_r;
  logic               changed_r;

  cell_ctrl_t         ctrl;
  logic [DIG_W-1:0]   digits [NUM_DIGITS];
  logic               top_carry, any_diff;
  logic               in_xfer, out_load, out_free, pos_ok;
  logic [DIG_W-1:0]   digit_at_pos;
  logic [BIN_W-1:0]   a_v, b_v, lo_v, hi_v, ld_clamp, ent_clamp, base_acc;
  logic               base_big, out_of_range;
  logic [BIN_W+3:0]   acc_ext, sum;
  logic [BCD_W-1:0]   bcd_vec;

  btr_chain #(.NUM_DIGITS(NUM_DIGITS)) u_chain (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .dab_in    (c_r[BIN_W-1]),
    .digits    (digits),
    .top_carry (top_carry),
    .any_diff  (any_diff)
  );

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;
  assign pos_ok      = (32'(pos_r) < 32'(NUM_DIGITS));

  // effective range
  always_comb begin
    a_v  = (min_r > max_r) ? max_r : min_r;
    b_v  = (min_r > max_r) ? min_r : max_r;
    lo_v = (a_v > TOP_VAL) ? TOP_VAL : a_v;
    hi_v = (b_v > TOP_VAL) ? TOP_VAL : b_v;
  end

  always_comb begin
    digit_at_pos = DIG_ZERO;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if ((i < (1 << POS_W)) && (pos_r == POS_W'(i))) begin
        digit_at_pos = digits[i];
      end
    end
    bcd_vec = '0;
    for (int i = 0; i < SHOWN; i++) begin
      bcd_vec[DIG_W*i +: DIG_W] = digits[i];
    end
  end

  always_comb begin
    ld_clamp     = (load_r < lo_r) ? lo_r : ((load_r > hi_r) ? hi_r : load_r);
    ent_clamp    = big_r ? hi_r : ((acc_r < lo_r) ? lo_r : ((acc_r > hi_r) ? hi_r : acc_r));
    out_of_range = big_r || (acc_r < lo_r) || (acc_r > hi_r);
    base_acc     = (cnt_r == '0) ? '0 : acc_r;
    base_big     = (cnt_r == '0) ? 1'b0 : big_r;
    acc_ext      = {4'b0, base_acc};
    sum          = (acc_ext << 3) + (acc_ext << 1) + {{BIN_W{1'b0}}, digits[NUM_DIGITS-1]};
  end

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = '0;
    clamp_mode_nxt = clamp_mode_r;
    ovf_nxt        = ovf_r;
    acc_nxt        = acc_r;
    big_nxt        = big_r;
    c_nxt          = c_r;
    out_load       = 1'b0;
    ctrl.op        = CELL_HOLD;
    ctrl.up        = (cmd_r == CMD_UP);
    ctrl.pos       = pos_r;
    ctrl.digit     = dig_r;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          ctrl.op   = CELL_SAVE;
          state_nxt = ST_START;
        end
      end
      ST_START: begin
        ovf_nxt        = 1'b0;
        clamp_mode_nxt = 1'b0;
        state_nxt      = ST_MEASURE;
        case (cmd_r)
          CMD_UP, CMD_DOWN: begin
            if (pos_ok) begin
              ctrl.op   = CELL_STEP;
              state_nxt = ST_CARRY;
            end
          end
          CMD_ENTER: begin
            if (pos_ok && (dig_r <= DIG_NINE) && (digit_at_pos != dig_r)) begin
              ctrl.op        = CELL_ENTER;
              clamp_mode_nxt = 1'b1;
              state_nxt      = ST_SCAN;
            end
          end
          CMD_LOAD: begin
            ctrl.op   = CELL_CLEAR;
            c_nxt     = ld_clamp;
            state_nxt = ST_DABBLE;
          end
          default: state_nxt = ST_MEASURE;
        endcase
      end
      ST_CARRY: begin
        ctrl.op = CELL_CARRY;
        ovf_nxt = ovf_r || top_carry;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == LAST_DIG) begin
          cnt_nxt = '0;
          if (ovf_r || top_carry) begin
            ctrl.op   = CELL_RESTORE;
            state_nxt = ST_MEASURE;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN, ST_MEASURE: begin
        ctrl.op = CELL_ROTATE;
        acc_nxt = sum[BIN_W-1:0];
        big_nxt = base_big || (|sum[BIN_W+3:BIN_W]);
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == LAST_DIG) begin
          cnt_nxt   = '0;
          state_nxt = (state_r == ST_SCAN) ? ST_JUDGE : ST_DONE;
        end
      end
      ST_JUDGE: begin
        state_nxt = ST_MEASURE;
        if (clamp_mode_r) begin
          ctrl.op   = CELL_CLEAR;
          c_nxt     = ent_clamp;
          state_nxt = ST_DABBLE;
        end else if (out_of_range) begin
          ctrl.op = CELL_RESTORE;
        end
      end
      ST_DABBLE: begin
        ctrl.op = CELL_DABBLE;
        c_nxt   = c_r << 1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == LAST_BIT) begin
          cnt_nxt   = '0;
          state_nxt = ST_MEASURE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      min_r       <= MIN_RESET;
      max_r       <= MAX_RESET;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_MIN: min_r <= cfg_data;
          CFG_MAX: max_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    lo_r         <= lo_v;
    hi_r         <= hi_v;
    clamp_mode_r <= clamp_mode_nxt;
    ovf_r        <= ovf_nxt;
    acc_r        <= acc_nxt;
    big_r        <= big_nxt;
    c_r          <= c_nxt;
    if (in_xfer) begin
      cmd_r  <= cmd_t'(in_ch.cmd);
      pos_r  <= in_ch.position;
      dig_r  <= in_ch.digit_in;
      load_r <= in_ch.load_value;
    end
    if (out_load) begin
      value_r   <= acc_r;
      bcd_r     <= bcd_vec;
      changed_r <= any_diff;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.value_out = value_r;
  assign out_ch.bcd_out   = bcd_r;
  assign out_ch.changed   = changed_r;

endmodule

[rtl/btr_check.sv]
module btr_check (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [btr_pkg::BCD_W-1:0]    bcd_out
);
  import btr_pkg::*;

  logic bcd_ok;

  always_comb begin
    bcd_ok = 1'b1;
    for (int i = 0; i < BCD_SLOTS; i++) begin
      if (bcd_out[DIG_W*i +: DIG_W] > DIG_NINE) begin
        bcd_ok = 1'b0;
      end
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(bcd_out))
    else $error("result dropped or changed while stalled");

  a_bcd_digits: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> bcd_ok)
    else $error("result holds a non-decimal digit");

  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is in progress");

  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result appeared one cycle after input transfer");

endmodule

bind bcd_tuning_register_top btr_check u_btr_check (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .bcd_out   (out_ch.bcd_out)
);

[sim/tb.sv]
module tb;
  import btr_pkg::*;

  localparam int DIGITS = 8;
  localparam int unsigned VALUE_TOP = 99_999_999;
  localparam int unsigned BIN_ALL = (1 << BIN_W) - 1;
  localparam int SETTLE_CYCLES = 60;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    cmd_t             cmd;
    logic [POS_W-1:0] position;
    logic [DIG_W-1:0] digit_in;
    logic [BIN_W-1:0] load_value;
  } tune_item_t;

  typedef struct packed {
    logic [BIN_W-1:0] value_out;
    logic [BCD_W-1:0] bcd_out;
    logic             changed;
  } tune_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_MIN;
  logic [BIN_W-1:0] cfg_data = '0;

  logic feed_valid = 1'b0;
  tune_item_t feed_item = '0;
  logic take_ready = 1'b0;
  logic in_taken = 1'b0;

  int feed_idle_pct = 29;
  int take_idle_pct = 76;
  logic hold_req = 1'b0;
  int hold_left = 0;
  logic hold_busy;

  int fault_count = 0;

  tune_item_t tune_queue [$];
  tune_result_t tune_expect [$];

  // predictor state
  logic [BCD_W-1:0] tune_store = RESET_BCD;
  logic [BIN_W-1:0] range_min = MIN_RESET;
  logic [BIN_W-1:0] range_max = MAX_RESET;

  btr_in_if in_ch ();
  btr_out_if out_ch ();

  assign in_ch.valid      = feed_valid;
  assign in_ch.cmd        = feed_item.cmd;
  assign in_ch.position   = feed_item.position;
  assign in_ch.digit_in   = feed_item.digit_in;
  assign in_ch.load_value = feed_item.load_value;
  assign out_ch.ready     = take_ready;
  assign hold_busy        = hold_left > 0;

  bcd_tuning_register_top #(.NUM_DIGITS(DIGITS)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  always #10 clk = ~clk;

  function automatic int unsigned decimal_of(input logic [BCD_W-1:0] b);
    int unsigned v;
    v = 0;
    for (int i = DIGITS - 1; i >= 0; i--) begin
      v = v * 10 + int'(b[DIG_W*i +: DIG_W]);
    end
    return v;
  endfunction

  function automatic logic [BCD_W-1:0] bcd_of(input int unsigned v);
    logic [BCD_W-1:0] b;
    b = '0;
    for (int i = 0; i < DIGITS; i++) begin
      b[DIG_W*i +: DIG_W] = DIG_W'(v % 10);
      v = v / 10;
    end
    return b;
  endfunction

  function automatic void tune_band(output int unsigned lo, output int unsigned hi);
    int unsigned a, b, t;
    a = range_min;
    b = range_max;
    if (a > b) begin
      t = a;
      a = b;
      b = t;
    end
    lo = (a > VALUE_TOP) ? VALUE_TOP : a;
    hi = (b > VALUE_TOP) ? VALUE_TOP : b;
  endfunction

  function automatic int unsigned clamp_tune(input int unsigned v);
    int unsigned lo, hi;
    tune_band(lo, hi);
    if (v < lo) v = lo;
    if (v > hi) v = hi;
    return v;
  endfunction

  function automatic tune_result_t tune(input tune_item_t it);
    tune_result_t r;
    logic [BCD_W-1:0] saved;
    logic [DIG_W-1:0] stop_dig, d;
    int unsigned prior, lo, hi, v;
    int p;
    bit up, movable, done;
    prior = decimal_of(tune_store);
    p = int'(it.position);
    up = it.cmd == CMD_UP;
    case (it.cmd)
      CMD_UP, CMD_DOWN: begin
        if (p < DIGITS) begin
          stop_dig = up ? DIG_NINE : DIG_ZERO;
          movable = 1'b0;
          for (int i = p; i < DIGITS; i++) begin
            if (tune_store[DIG_W*i +: DIG_W] != stop_dig) movable = 1'b1;
          end
          if (movable) begin
            saved = tune_store;
            done = 1'b0;
            for (int i = p; i < DIGITS; i++) begin
              d = tune_store[DIG_W*i +: DIG_W];
              if (!done) begin
                if (d == stop_dig) begin
                  tune_store[DIG_W*i +: DIG_W] = up ? DIG_ZERO : DIG_NINE;
                end else begin
                  tune_store[DIG_W*i +: DIG_W] = up ? d + 1'b1 : d - 1'b1;
                  done = 1'b1;
                end
              end
            end
            v = decimal_of(tune_store);
            tune_band(lo, hi);
            if (v < lo || v > hi) tune_store = saved;
          end
        end
      end
      CMD_ENTER: begin
        if (p < DIGITS && it.digit_in <= DIG_NINE &&
            tune_store[DIG_W*p +: DIG_W] != it.digit_in) begin
          tune_store[DIG_W*p +: DIG_W] = it.digit_in;
          tune_store = bcd_of(clamp_tune(decimal_of(tune_store)));
        end
      end
      default: begin
        tune_store = bcd_of(clamp_tune(int'(it.load_value)));
      end
    endcase
    r.value_out = BIN_W'(decimal_of(tune_store));
    r.bcd_out = tune_store;
    r.changed = decimal_of(tune_store) != prior;
    return r;
  endfunction

  function automatic tune_item_t random_tune_item();
    tune_item_t it;
    int unsigned lo, hi, pick;
    tune_band(lo, hi);
    it.position = ($urandom_range(2) == 0) ? POS_W'($urandom_range(2)) :
                                             POS_W'($urandom_range(7));
    it.digit_in = ($urandom_range(9) == 0) ? DIG_W'($urandom_range(15, 10)) :
                                             DIG_W'($urandom_range(9));
    it.load_value = BIN_W'($urandom);
    pick = $urandom_range(99);
    if (pick < 36) it.cmd = CMD_UP;
    else if (pick < 72) it.cmd = CMD_DOWN;
    else if (pick < 87) it.cmd = CMD_ENTER;
    else it.cmd = CMD_LOAD;
    if (it.cmd == CMD_LOAD) begin
      case ($urandom_range(3))
        0: it.load_value = BIN_W'($urandom_range(hi, lo));
        1: it.load_value = BIN_W'(lo);
        2: it.load_value = BIN_W'(hi);
        default: ;
      endcase
    end
    return it;
  endfunction

  task automatic queue_tune(input cmd_t c, input int p, input int d, input int unsigned l);
    tune_item_t it;
    it.cmd = c;
    it.position = POS_W'(p);
    it.digit_in = DIG_W'(d);
    it.load_value = BIN_W'(l);
    tune_queue = {tune_queue, it};
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    fault_count++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= BIN_W'(data);
    if (idx == CFG_MIN) range_min = BIN_W'(data);
    else range_max = BIN_W'(data);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // wait until every queued item has been sent and answered
  task automatic settle();
    while (tune_queue.size() != 0 || feed_valid || tune_expect.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (rst_n && (!feed_valid || in_taken)) begin
      if (tune_queue.size() > 0 && $urandom_range(99) >= feed_idle_pct) begin
        feed_item <= tune_queue.pop_front();
        feed_valid <= 1'b1;
      end else begin
        feed_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    take_ready <= rst_n && !hold_busy && ($urandom_range(99) >= take_idle_pct);
  end

  always @(negedge clk) begin
    if (hold_left > 0) hold_left <= hold_left - 1;
    else if (hold_req) hold_left <= HOLD_CYCLES;
  end

  always @(posedge clk) begin : watch
    tune_item_t seen;
    tune_result_t want;
    in_taken <= rst_n && in_ch.valid && in_ch.ready;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        seen.cmd = cmd_t'(in_ch.cmd);
        seen.position = in_ch.position;
        seen.digit_in = in_ch.digit_in;
        seen.load_value = in_ch.load_value;
        tune_expect = {tune_expect, tune(seen)};
      end
      if (out_ch.valid && out_ch.ready) begin
        if (tune_expect.size() == 0) begin
          report_mismatch("result transfer with none pending", out_ch.value_out, 0);
        end else begin
          want = tune_expect.pop_front();
          if (out_ch.value_out !== want.value_out)
            report_mismatch("value_out", out_ch.value_out, want.value_out);
          if (out_ch.bcd_out !== want.bcd_out)
            report_mismatch("bcd_out", out_ch.bcd_out, want.bcd_out);
          if (out_ch.changed !== want.changed)
            report_mismatch("changed", out_ch.changed, want.changed);
        end
      end
    end
  end

  initial begin
    #20_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    int unsigned lo_set, hi_set;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // default range, value 14070000
    queue_tune(CMD_ENTER, 7, 1, 0);
    queue_tune(CMD_ENTER, 0, 15, 0);
    queue_tune(CMD_UP, 0, 0, 0);
    queue_tune(CMD_DOWN, 0, 0, 0);
    queue_tune(CMD_DOWN, 0, 0, 0);
    queue_tune(CMD_UP, 0, 0, 0);
    queue_tune(CMD_UP, 7, 0, 0);
    queue_tune(CMD_UP, 7, 0, 0);
    queue_tune(CMD_UP, 7, 0, 0);
    queue_tune(CMD_LOAD, 0, 0, 0);
    queue_tune(CMD_DOWN, 0, 0, 0);
    queue_tune(CMD_LOAD, 0, 0, BIN_ALL);
    queue_tune(CMD_ENTER, 7, 9, 0);
    queue_tune(CMD_ENTER, 7, 0, 0);
    settle();

    write_reg(CFG_MIN, 0);
    write_reg(CFG_MAX, VALUE_TOP);
    queue_tune(CMD_LOAD, 0, 0, VALUE_TOP);
    queue_tune(CMD_UP, 0, 0, 0);
    queue_tune(CMD_UP, 5, 0, 0);
    queue_tune(CMD_DOWN, 7, 0, 0);
    queue_tune(CMD_LOAD, 0, 0, 0);
    queue_tune(CMD_DOWN, 3, 0, 0);
    queue_tune(CMD_UP, 7, 0, 0);
    queue_tune(CMD_ENTER, 0, 9, 0);
    queue_tune(CMD_LOAD, 0, 0, 27'h5555555);
    queue_tune(CMD_LOAD, 0, 0, 27'h2AAAAAA);
    queue_tune(CMD_LOAD, 0, 0, VALUE_TOP + 1);
    settle();

    for (int k = 0; k < 8; k++) begin
      case (k)
        0: begin lo_set = BIN_ALL; hi_set = 0; end
        1: begin lo_set = 12_345_678; hi_set = 12_345_699; end
        2: begin lo_set = 500_000; hi_set = 39_999_999; end
        3: begin lo_set = VALUE_TOP; hi_set = VALUE_TOP; end
        4: begin lo_set = 0; hi_set = 0; end
        5: begin lo_set = 90_000_000; hi_set = BIN_ALL; end
        6: begin lo_set = 5000; hi_set = 100; end
        default: begin lo_set = 0; hi_set = VALUE_TOP; end
      endcase
      feed_idle_pct = (k < 3) ? 29 : (k < 6) ? 76 : 0;
      take_idle_pct = (k < 3) ? 76 : (k < 6) ? 29 : 0;
      write_reg(CFG_MIN, lo_set);
      write_reg(CFG_MAX, hi_set);
      repeat (250) tune_queue = {tune_queue, random_tune_item()};
      if (k == 1) begin
        // long output stall while input keeps offering
        hold_req = 1'b1;
        while (!hold_busy) @(negedge clk);
        hold_req = 1'b0;
      end
      settle();
    end

    if (fault_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
